@@ rtl/tssd_pkg.sv @@
package tssd_pkg;

    // default width of one sample component
    localparam int SAMPLE_WIDTH_DEF = 16;

    // phase and correlation fields
    localparam int PHASE_W = 16;
    localparam int CORR_W  = 16;

    // decimation factor register
    localparam int                SPS_W     = 8;
    localparam logic [SPS_W-1:0]  SPS_RESET = 8'd8;

    // sample and marker indexes
    localparam int IDX_W = 64;

    // tuser bit positions on the slave side
    localparam int USR_MARKER = 0;
    localparam int USR_CORR   = 1;
    localparam int S_USER_W   = 2;
    localparam int M_USER_W   = 1;

endpackage

@@ rtl/tag_synced_symbol_decimator_core.sv @@
// Tag-synced symbol decimator.
// The slave stream carries one complex sample per transaction, with an optional
// phase marker and correlation estimate. A marker is taken unless an earlier
// marker lies fewer than samples_per_symbol samples back, a correlation comes
// with the new one, and that correlation is below the stored one. A taken
// marker syncs the block and restarts the symbol count; once synced, the sample
// at each taken marker and every samples_per_symbol samples after an emission
// leaves on the master stream, with marker flag and, for a taken marker, phase.
// Configuration: one write channel loads samples_per_symbol; write only while
// no sample is in flight.
// The sample passes the input register, then the result register, before master
// tvalid rises; a stall on the master side can hold it between them.
// Throughput: one sample per cycle while the master side does not stall; the
// input register moves on whenever the result register is empty or being taken,
// so a stall on the master side holds both stages and drops o_s_tready only
// when both are full and i_m_tready is low. Samples that produce no symbol
// leave nothing on the master side.
// Reset: clears sync, counters, stored correlation and both valid flags, and
// sets samples_per_symbol to 8. No clearing pass is needed.
module tag_synced_symbol_decimator_core
    import tssd_pkg::*;
#(
    parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    // configuration write: samples_per_symbol
    input  logic                i_cfg_valid,
    output logic                o_cfg_ready,
    input  logic [SPS_W-1:0]    i_cfg_data,
    // slave stream
    input  logic                i_s_tvalid,
    output logic                o_s_tready,
    // tdata from bit 0: in_i, in_q, phase_value, corr_value, zero fill
    input  logic [((2*SAMPLE_WIDTH+PHASE_W+CORR_W+7)/8)*8-1:0] i_s_tdata,
    // tuser from bit 0: phase_marker, corr_present
    input  logic [S_USER_W-1:0] i_s_tuser,
    // master stream
    output logic                o_m_tvalid,
    input  logic                i_m_tready,
    // tdata from bit 0: out_i, out_q, out_phase, zero fill
    output logic [((2*SAMPLE_WIDTH+PHASE_W+7)/8)*8-1:0] o_m_tdata,
    // tuser from bit 0: out_marker
    output logic [M_USER_W-1:0] o_m_tuser
);

    localparam int S_DATA_W = ((2*SAMPLE_WIDTH+PHASE_W+CORR_W+7)/8)*8;
    localparam int M_DATA_W = ((2*SAMPLE_WIDTH+PHASE_W+7)/8)*8;
    localparam int Q_LO     = SAMPLE_WIDTH;
    localparam int PH_LO    = 2*SAMPLE_WIDTH;
    localparam int CR_LO    = 2*SAMPLE_WIDTH + PHASE_W;
    localparam int M_USED_W = 2*SAMPLE_WIDTH + PHASE_W;

    // configuration and tracking state
    logic [SPS_W-1:0]    r_sps;
    logic [IDX_W-1:0]    r_sample_index;
    logic [IDX_W-1:0]    r_last_marker_index;
    logic [CORR_W-1:0]   r_last_corr;
    logic [SPS_W-1:0]    r_symbol_count;
    logic                r_synced;

    // input register
    logic                r_in_valid;
    logic [S_DATA_W-1:0] r_in_data;
    logic [S_USER_W-1:0] r_in_user;

    // result register
    logic                r_out_valid;
    logic [M_DATA_W-1:0] r_out_data;
    logic [M_USER_W-1:0] r_out_user;

    // decision logic
    logic                advance;
    logic                proc;
    logic                marker;
    logic                corr_ok;
    logic [CORR_W-1:0]   corr;
    logic [IDX_W-1:0]    mark_gap;
    logic                near;
    logic                fake;
    logic                took;
    logic [SPS_W-1:0]    cnt_mark;
    logic                emit;
    logic [SPS_W-1:0]    cnt_emit;
    logic [SPS_W-1:0]    n_symbol_count;
    logic [M_DATA_W-1:0] n_out_data;

    assign o_cfg_ready = 1'b1;
    assign advance     = !r_out_valid || i_m_tready;
    assign o_s_tready  = !r_in_valid || advance;
    assign proc        = r_in_valid && advance;

    assign o_m_tvalid  = r_out_valid;
    assign o_m_tdata   = r_out_data;
    assign o_m_tuser   = r_out_user;

    // marker acceptance and emission decision
    always_comb begin
        marker   = r_in_user[USR_MARKER];
        corr_ok  = r_in_user[USR_CORR];
        corr     = r_in_data[CR_LO +: CORR_W];
        mark_gap = r_sample_index - r_last_marker_index;
        near     = (mark_gap[IDX_W-1:SPS_W] == '0) && (mark_gap[SPS_W-1:0] < r_sps);
        fake     = marker && (r_last_marker_index != '0) && corr_ok && near
                   && (corr < r_last_corr);
        took     = marker && !fake;
        cnt_mark = took ? '0 : r_symbol_count;
        emit     = (r_synced || took)
                   && (took || ((r_sps != '0) && (cnt_mark == r_sps)));
        cnt_emit = emit ? '0 : cnt_mark;
        n_symbol_count = (cnt_emit == '1) ? cnt_emit : cnt_emit + 1'b1;

        n_out_data = '0;
        n_out_data[M_USED_W-1:0] = {took ? r_in_data[PH_LO +: PHASE_W] : {PHASE_W{1'b0}},
                                    r_in_data[Q_LO +: SAMPLE_WIDTH],
                                    r_in_data[0 +: SAMPLE_WIDTH]};
    end

    // configuration register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sps <= SPS_RESET;
        end else if (i_cfg_valid) begin
            r_sps <= i_cfg_data;
        end
    end

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_s_tready) begin
            r_in_valid <= i_s_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_s_tready && i_s_tvalid) begin
            r_in_data <= i_s_tdata;
            r_in_user <= i_s_tuser;
        end
    end

    // tracking state, updated once per processed sample
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sample_index      <= '0;
            r_last_marker_index <= '0;
            r_last_corr         <= '0;
            r_symbol_count      <= '0;
            r_synced            <= 1'b0;
        end else if (proc) begin
            r_sample_index <= r_sample_index + 1'b1;
            r_symbol_count <= n_symbol_count;
            if (took) begin
                r_synced            <= 1'b1;
                r_last_marker_index <= r_sample_index;
                if (corr_ok) begin
                    r_last_corr <= corr;
                end
            end
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (proc) begin
            r_out_valid <= emit;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (proc && emit) begin
            r_out_data <= n_out_data;
            r_out_user <= took;
        end
    end

endmodule
